[rtl/fbc_pkg.sv]
// shared types and constants for the frustum box cull test
package fbc_pkg;

	// plane set held in configuration
	localparam int NUM_PLANES = 6;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd5;

	// field widths and plane packing
	localparam int COORD_W  = 16;
	localparam int NUM_AXES = 3;
	localparam int DIST_LSB = NUM_AXES * COORD_W;
	localparam int PROD_W   = 2 * COORD_W;
	// three products plus the shifted distance (fraction bits at most 15)
	localparam int SUM_W    = PROD_W + 2;

	// stream widths
	localparam int IN_W  = 2 * NUM_AXES * COORD_W;
	localparam int OUT_W = 8;

	typedef logic [CFG_W-1:0] plane_t;
	typedef plane_t [NUM_PLANES-1:0] plane_set_t;

	// box as it sits on the input bus: min corner in the low half, x lowest
	typedef struct packed {
		logic [NUM_AXES-1:0][COORD_W-1:0] hi;
		logic [NUM_AXES-1:0][COORD_W-1:0] lo;
	} box_t;

	// stage load strobes from the pipeline control to the plane units
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} fbc_adv_t;

endpackage

[rtl/fbc_plane_regs.sv]
// frustum plane configuration registers
module fbc_plane_regs
	import fbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output plane_set_t           planes
);

	plane_set_t planes_q;

	// register write decode, indexes past the plane list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			planes_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_NEAR:   planes_q[0] <= cfg_data;
				REG_PLANE_FAR:    planes_q[1] <= cfg_data;
				REG_PLANE_TOP:    planes_q[2] <= cfg_data;
				REG_PLANE_BOTTOM: planes_q[3] <= cfg_data;
				REG_PLANE_RIGHT:  planes_q[4] <= cfg_data;
				REG_PLANE_LEFT:   planes_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign planes = planes_q;

endmodule

[rtl/fbc_plane_eval.sv]
// one plane: corner products, per-axis corner pick and sums, distance compare
module fbc_plane_eval
	import fbc_pkg::*;
#(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic     clk,
	input  fbc_adv_t adv,
	input  plane_t   plane,
	input  box_t     box_s1,
	output logic     touch_ok,
	output logic     inside_ok
);

	logic signed [COORD_W-1:0] nrm [NUM_AXES];
	logic signed [COORD_W-1:0] plane_d;

	logic signed [PROD_W-1:0] prod_lo_s2 [NUM_AXES];
	logic signed [PROD_W-1:0] prod_hi_s2 [NUM_AXES];
	logic [NUM_AXES-1:0]      neg_s2;

	logic signed [PROD_W-1:0] t_term [NUM_AXES];
	logic signed [PROD_W-1:0] i_term [NUM_AXES];

	logic signed [SUM_W-1:0] touch_sum_s3;
	logic signed [SUM_W-1:0] inside_sum_s3;
	logic signed [SUM_W-1:0] bias;
	logic signed [SUM_W-1:0] touch_tot;
	logic signed [SUM_W-1:0] inside_tot;

	// unpack normal and distance
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			nrm[a] = plane[a*COORD_W +: COORD_W];
		end
		plane_d = plane[DIST_LSB +: COORD_W];
	end

	// stage 2: normal times min and max coordinate on each axis
	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_lo_s2[a] <= nrm[a] * $signed(box_s1.lo[a]);
				prod_hi_s2[a] <= nrm[a] * $signed(box_s1.hi[a]);
				neg_s2[a]     <= nrm[a][COORD_W-1];
			end
		end
	end

	// touch corner follows normal sign, the worst corner takes the smaller product
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			t_term[a] = neg_s2[a] ? prod_lo_s2[a] : prod_hi_s2[a];
			i_term[a] = (prod_lo_s2[a] < prod_hi_s2[a]) ? prod_lo_s2[a] : prod_hi_s2[a];
		end
	end

	// stage 3: sum of the three axis terms
	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			touch_sum_s3  <= SUM_W'(t_term[0]) + SUM_W'(t_term[1]) + SUM_W'(t_term[2]);
			inside_sum_s3 <= SUM_W'(i_term[0]) + SUM_W'(i_term[1]) + SUM_W'(i_term[2]);
		end
	end

	// add scaled distance, a negative total means behind the plane
	always_comb begin
		bias       = SUM_W'(plane_d) <<< NORMAL_FRAC_BITS;
		touch_tot  = touch_sum_s3 + bias;
		inside_tot = inside_sum_s3 + bias;
		touch_ok   = ~touch_tot[SUM_W-1];
		inside_ok  = ~inside_tot[SUM_W-1];
	end

endmodule

[rtl/frustum_box_cull_test.sv]
// top level: frustum versus axis-aligned box cull test, four-stage pipeline
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  box min x,y,z then max x,y,z, 16 bits each
//   m_*      out        m_tvalid/m_tready  touches_frustum, wholly_inside
//   cfg_*    in         cfg_we             plane register index and 64-bit value
//
// one box per cycle unless a held result backs up the whole pipe
// stages: input register, 36 16x16 multipliers, axis pick and sum, distance
// compare with the six-plane reduction into the output register
// each stage holds only when the stage after it is full and held, so bubbles
// close up and input is taken while a result waits
// reset clears the pipeline valid bits and the plane registers (all planes zero)
module frustum_box_cull_test
	import fbc_pkg::*;
#(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// touches_frustum, wholly_inside, zero padding
	output logic [OUT_W-1:0]     m_tdata
);

	plane_set_t planes;
	fbc_adv_t   adv;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;
	box_t box_s1;
	logic touch_s4, inside_s4;

	logic [NUM_PLANES-1:0] touch_vec;
	logic [NUM_PLANES-1:0] inside_vec;

	// plane storage
	fbc_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	// a stage may load when empty or when its content moves on
	assign ready4 = !valid_s4 || m_tready;
	assign ready3 = !valid_s3 || ready4;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;
	assign s_tready = ready1;

	assign adv.ld_s2 = ready2 && valid_s1;
	assign adv.ld_s3 = ready3 && valid_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= s_tvalid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) valid_s3 <= valid_s2;
			if (ready4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: box register
	always_ff @(posedge clk) begin
		if (ready1 && s_tvalid) begin
			box_s1 <= s_tdata;
		end
	end

	// per-plane datapath, stages 2 and 3
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		fbc_plane_eval #(
			.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
		) u_eval (
			.clk       (clk),
			.adv       (adv),
			.plane     (planes[p]),
			.box_s1    (box_s1),
			.touch_ok  (touch_vec[p]),
			.inside_ok (inside_vec[p])
		);
	end

	// stage 4: reduce over planes into the output register
	always_ff @(posedge clk) begin
		if (ready4 && valid_s3) begin
			touch_s4  <= &touch_vec;
			inside_s4 <= &inside_vec;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {{(OUT_W-2){1'b0}}, inside_s4, touch_s4};

endmodule

[rtl/fbc_checker.sv]
// port-level checks for the frustum box cull test, bound to the top level
module fbc_checker
	import fbc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// inside every plane implies touching the frustum, padding stays zero
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] || !m_tdata[1]) && (m_tdata[OUT_W-1:2] == '0))
		else $error("inconsistent result flags");

	// input is refused only when the whole pipe backs up behind a held result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	// a result after an empty output comes from an earlier input transfer
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
		else $error("result without matching input transfer");

endmodule

bind frustum_box_cull_test fbc_checker u_fbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
